### hdl/tacs_pkg.sv
package tacs_pkg;

  localparam int ADDR_W    = 8;
  localparam int DATA_W    = 8;
  localparam int MEM_DEPTH = 256;

  localparam logic [ADDR_W-1:0] OPCODE_SLOT   = 8'd0;
  localparam logic [ADDR_W-1:0] START_RESET   = 8'd1;
  localparam logic [ADDR_W-1:0] CEILING_RESET = 8'd253;

  // item kinds
  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_STEP    = 2'd2;
  localparam logic [1:0] KIND_RESTART = 2'd3;

  // configuration register indexes
  localparam int         CFG_INDEX_W = 1;
  localparam logic [0:0] CFG_START   = 1'b0;
  localparam logic [0:0] CFG_CEILING = 1'b1;

  // opcodes
  localparam logic [DATA_W-1:0] OP_HALT = 8'd0;
  localparam logic [DATA_W-1:0] OP_LDA  = 8'd1;
  localparam logic [DATA_W-1:0] OP_LDB  = 8'd2;
  localparam logic [DATA_W-1:0] OP_ADD  = 8'd3;
  localparam logic [DATA_W-1:0] OP_BEEP = 8'd4;
  localparam logic [DATA_W-1:0] OP_STO  = 8'd5;
  localparam logic [DATA_W-1:0] OP_PRN  = 8'd6;

  // memory port operations
  typedef logic [2:0] mem_op_t;
  localparam mem_op_t MEM_NONE        = 3'd0;
  localparam mem_op_t MEM_CLEAR       = 3'd1;
  localparam mem_op_t MEM_WRITE_ITEM  = 3'd2;
  localparam mem_op_t MEM_READ_ITEM   = 3'd3;
  localparam mem_op_t MEM_READ_PC     = 3'd4;
  localparam mem_op_t MEM_WRITE_SLOT  = 3'd5;
  localparam mem_op_t MEM_WRITE_STORE = 3'd6;
  localparam mem_op_t MEM_READ_IND    = 3'd7;

  // register updates, most of them taken from the memory read data
  typedef logic [2:0] act_t;
  localparam act_t ACT_NONE    = 3'd0;
  localparam act_t ACT_READ    = 3'd1;
  localparam act_t ACT_OPCODE  = 3'd2;
  localparam act_t ACT_IMM     = 3'd3;
  localparam act_t ACT_IND     = 3'd4;
  localparam act_t ACT_RESTART = 3'd5;

  localparam int IN_DATA_W     = 16;
  localparam int OUT_FIELDS_W  = 43;
  localparam int OUT_DATA_W    = 48;

  typedef struct packed {
    logic    load_item;
    mem_op_t mem_op;
    logic    pc_inc;
    act_t    act;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic              halted;
    logic              over_ceiling;
    logic [DATA_W-1:0] op_now;
    logic [DATA_W-1:0] op;
    logic              clear_done;
    logic              out_free;
  } sts_t;

endpackage

### hdl/tiny_accumulator_cpu_step_core.sv
// channel  | dir | handshake            | payload
// s_       | in  | s_tvalid / s_tready  | s_tuser: kind; s_tdata: address, write_data
// m_       | out | m_tvalid / m_tready  | m_tdata: result fields
// cfg_     | in  | cfg_we               | cfg_addr: register index; cfg_wdata: value
//
// Item length is set by the single memory port: a step fetches the opcode; loads, stores and
// prints then fetch an immediate, a store then writes memory and a print reads it indirectly;
// a halted step, a fetch past the ceiling and a restart go no further than that.
// Reset: a clearing pass writes zero to all 256 memory bytes, one per cycle; s_tready stays
// low until the pass ends. Configuration writes are taken throughout.
// Stalls: the next item is accepted while a result waits in the output register; that item
// holds in its last cycle until m_tready frees the register.
module tiny_accumulator_cpu_step_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [1:0]                           s_tuser,  // [1:0] kind
  input  logic [tacs_pkg::IN_DATA_W-1:0]       s_tdata,  // [7:0] address, [15:8] write_data
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [7:0] read_data, [8] printed, [16:9] print_value, [17] beeped, [18] halted,
  // [26:19] program_counter, [34:27] accumulator, [42:35] operand_register, [47:43] zero
  output logic [tacs_pkg::OUT_DATA_W-1:0]      m_tdata,
  input  logic                                 cfg_we,
  input  logic [tacs_pkg::CFG_INDEX_W-1:0]     cfg_addr,
  input  logic [tacs_pkg::DATA_W-1:0]          cfg_wdata
);

  tacs_pkg::cmd_t cmd;
  tacs_pkg::sts_t sts;

  tacs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_kind   (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  tacs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_data    (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

### hdl/tacs_ram.sv
module tacs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hdl/tacs_ctrl.sv
module tacs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [1:0]       s_kind,
  input  tacs_pkg::sts_t   sts,
  output tacs_pkg::cmd_t   cmd
);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_WRITE  = 4'd2;
  localparam logic [3:0] ST_READ   = 4'd3;
  localparam logic [3:0] ST_RWAIT  = 4'd4;
  localparam logic [3:0] ST_OPC    = 4'd5;
  localparam logic [3:0] ST_IMM    = 4'd6;
  localparam logic [3:0] ST_IMMW   = 4'd7;
  localparam logic [3:0] ST_STORE  = 4'd8;
  localparam logic [3:0] ST_IND    = 4'd9;
  localparam logic [3:0] ST_INDW   = 4'd10;
  localparam logic [3:0] ST_FINISH = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.mem_op = tacs_pkg::MEM_CLEAR;
        if (sts.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.load_item = 1'b1;
          unique case (s_kind)
            tacs_pkg::KIND_WRITE: state_next = ST_WRITE;
            tacs_pkg::KIND_READ:  state_next = ST_READ;
            tacs_pkg::KIND_RESTART: begin
              cmd.act    = tacs_pkg::ACT_RESTART;
              state_next = ST_FINISH;
            end
            default: begin
              // fetch the opcode right away unless halted
              if (sts.halted) begin
                state_next = ST_FINISH;
              end else begin
                cmd.mem_op = tacs_pkg::MEM_READ_PC;
                cmd.pc_inc = 1'b1;
                state_next = ST_OPC;
              end
            end
          endcase
        end
      end
      ST_WRITE: begin
        cmd.mem_op = tacs_pkg::MEM_WRITE_ITEM;
        state_next = ST_FINISH;
      end
      ST_READ: begin
        cmd.mem_op = tacs_pkg::MEM_READ_ITEM;
        state_next = ST_RWAIT;
      end
      ST_RWAIT: begin
        cmd.act    = tacs_pkg::ACT_READ;
        state_next = ST_FINISH;
      end
      ST_OPC: begin
        cmd.mem_op = tacs_pkg::MEM_WRITE_SLOT;
        cmd.act    = tacs_pkg::ACT_OPCODE;
        if (!sts.over_ceiling &&
            (sts.op_now == tacs_pkg::OP_LDA || sts.op_now == tacs_pkg::OP_LDB ||
             sts.op_now == tacs_pkg::OP_STO || sts.op_now == tacs_pkg::OP_PRN)) begin
          state_next = ST_IMM;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_IMM: begin
        cmd.mem_op = tacs_pkg::MEM_READ_PC;
        cmd.pc_inc = 1'b1;
        state_next = ST_IMMW;
      end
      ST_IMMW: begin
        cmd.act = tacs_pkg::ACT_IMM;
        priority if (sts.op == tacs_pkg::OP_STO) begin
          state_next = ST_STORE;
        end else if (sts.op == tacs_pkg::OP_PRN) begin
          state_next = ST_IND;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_STORE: begin
        cmd.mem_op = tacs_pkg::MEM_WRITE_STORE;
        state_next = ST_FINISH;
      end
      ST_IND: begin
        cmd.mem_op = tacs_pkg::MEM_READ_IND;
        state_next = ST_INDW;
      end
      ST_INDW: begin
        cmd.act    = tacs_pkg::ACT_IND;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // hold the result until the output register frees up
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  a_step_fetch: assert property (@(posedge clk) disable iff (rst)
    (accept && s_kind == tacs_pkg::KIND_STEP && !sts.halted) |=> (state == ST_OPC))
    else $error("accepted step did not go to opcode decode");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over an untaken result");

  a_store_seq: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OPC && !sts.over_ceiling && sts.op_now == tacs_pkg::OP_STO)
    |=> (state == ST_IMM) ##1 (state == ST_IMMW) ##1 (state == ST_STORE))
    else $error("store opcode sequence broken");

endmodule

### hdl/tacs_datapath.sv
module tacs_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [tacs_pkg::IN_DATA_W-1:0]       s_data,
  input  logic                                 cfg_we,
  input  logic [tacs_pkg::CFG_INDEX_W-1:0]     cfg_addr,
  input  logic [tacs_pkg::DATA_W-1:0]          cfg_wdata,
  input  tacs_pkg::cmd_t                       cmd,
  output tacs_pkg::sts_t                       sts,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [tacs_pkg::OUT_DATA_W-1:0]      m_tdata
);

  logic [tacs_pkg::ADDR_W-1:0]       item_addr;
  logic [tacs_pkg::DATA_W-1:0]       item_wdata;
  logic [tacs_pkg::ADDR_W-1:0]       start_addr;
  logic [tacs_pkg::ADDR_W-1:0]       ceiling;
  logic [tacs_pkg::ADDR_W-1:0]       pc;
  logic [tacs_pkg::DATA_W-1:0]       reg_a;
  logic [tacs_pkg::DATA_W-1:0]       reg_b;
  logic                              halt;
  logic [tacs_pkg::DATA_W-1:0]       op;
  logic [tacs_pkg::DATA_W-1:0]       read_data;
  logic                              printed;
  logic [tacs_pkg::DATA_W-1:0]       print_value;
  logic                              beeped;
  logic [tacs_pkg::ADDR_W-1:0]       clr_cnt;
  logic [tacs_pkg::OUT_FIELDS_W-1:0] out_fields;

  logic                              ram_we;
  logic [tacs_pkg::ADDR_W-1:0]       ram_addr;
  logic [tacs_pkg::DATA_W-1:0]       ram_wdata;
  logic [tacs_pkg::DATA_W-1:0]       ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = pc;
    ram_wdata = ram_rdata;
    unique case (cmd.mem_op)
      tacs_pkg::MEM_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt;
        ram_wdata = '0;
      end
      tacs_pkg::MEM_WRITE_ITEM: begin
        ram_we    = 1'b1;
        ram_addr  = item_addr;
        ram_wdata = item_wdata;
      end
      tacs_pkg::MEM_READ_ITEM: ram_addr = item_addr;
      tacs_pkg::MEM_READ_PC:   ram_addr = pc;
      tacs_pkg::MEM_WRITE_SLOT: begin
        // copy the fetched opcode into its slot
        ram_we    = 1'b1;
        ram_addr  = tacs_pkg::OPCODE_SLOT;
        ram_wdata = ram_rdata;
      end
      tacs_pkg::MEM_WRITE_STORE: begin
        ram_we    = 1'b1;
        ram_addr  = reg_b;
        ram_wdata = reg_a;
      end
      tacs_pkg::MEM_READ_IND: ram_addr = reg_b;
      default: ram_addr = pc;
    endcase
  end

  tacs_ram #(
    .WIDTH (tacs_pkg::DATA_W),
    .DEPTH (tacs_pkg::MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.mem_op == tacs_pkg::MEM_CLEAR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_addr <= tacs_pkg::START_RESET;
      ceiling    <= tacs_pkg::CEILING_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tacs_pkg::CFG_START:   start_addr <= cfg_wdata;
        tacs_pkg::CFG_CEILING: ceiling    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_addr  <= s_data[tacs_pkg::ADDR_W-1:0];
      item_wdata <= s_data[tacs_pkg::IN_DATA_W-1:tacs_pkg::ADDR_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc          <= tacs_pkg::START_RESET;
      reg_a       <= '0;
      reg_b       <= '0;
      halt        <= 1'b0;
      op          <= '0;
      read_data   <= '0;
      printed     <= 1'b0;
      print_value <= '0;
      beeped      <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        read_data   <= '0;
        printed     <= 1'b0;
        print_value <= '0;
        beeped      <= 1'b0;
      end
      if (cmd.pc_inc) begin
        pc <= pc + 1'b1;
      end
      unique case (cmd.act)
        tacs_pkg::ACT_READ: read_data <= ram_rdata;
        tacs_pkg::ACT_OPCODE: begin
          op <= ram_rdata;
          if (sts.over_ceiling) begin
            halt <= 1'b1;
          end else begin
            priority case (ram_rdata)
              tacs_pkg::OP_HALT: halt   <= 1'b1;
              tacs_pkg::OP_ADD:  reg_a  <= reg_a + reg_b;
              tacs_pkg::OP_BEEP: beeped <= 1'b1;
              default: ;
            endcase
          end
        end
        tacs_pkg::ACT_IMM: begin
          if (op == tacs_pkg::OP_LDA) begin
            reg_a <= ram_rdata;
          end else begin
            reg_b <= ram_rdata;
          end
        end
        tacs_pkg::ACT_IND: begin
          reg_a       <= ram_rdata;
          printed     <= 1'b1;
          print_value <= ram_rdata;
        end
        tacs_pkg::ACT_RESTART: begin
          halt <= 1'b0;
          pc   <= start_addr;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_fields <= {reg_b, reg_a, pc, halt, beeped, print_value, printed, read_data};
    end
  end

  assign m_tdata = {{(tacs_pkg::OUT_DATA_W - tacs_pkg::OUT_FIELDS_W){1'b0}}, out_fields};

  assign sts.halted       = halt;
  assign sts.over_ceiling = (pc > ceiling);
  assign sts.op_now       = ram_rdata;
  assign sts.op           = op;
  assign sts.clear_done   = (clr_cnt == tacs_pkg::ADDR_W'(tacs_pkg::MEM_DEPTH - 1));
  assign sts.out_free     = !m_tvalid || m_tready;

endmodule

### bench/tb_tiny_accumulator_cpu_step_core.sv
module tb_tiny_accumulator_cpu_step_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 240;
  localparam int LONG_HOLD   = 200;

  // packed from the top bit down, so read_data lands in the lowest bits
  typedef struct packed {
    logic [7:0] operand_register;
    logic [7:0] accumulator;
    logic [7:0] program_counter;
    logic       halted;
    logic       beeped;
    logic [7:0] print_value;
    logic       printed;
    logic [7:0] read_data;
  } machine_out_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // cfg rows carry the register index in addr and the value in data
  typedef struct packed {
    row_kind_t  rk;
    logic [1:0] kind;
    logic [7:0] addr;
    logic [7:0] data;
    logic       typed;
    logic [7:0] exp_rd;
    logic [7:0] exp_pc;
  } dir_row_t;

  logic                             clk;
  logic                             rst;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [1:0]                       s_tuser;  // [1:0] kind
  logic [tacs_pkg::IN_DATA_W-1:0]   s_tdata;  // [7:0] address, [15:8] write_data
  logic                             m_tvalid;
  logic                             m_tready;
  // [7:0] read_data, [8] printed, [16:9] print_value, [17] beeped, [18] halted,
  // [26:19] program_counter, [34:27] accumulator, [42:35] operand_register
  logic [tacs_pkg::OUT_DATA_W-1:0]  m_tdata;
  logic                             cfg_we;
  logic [tacs_pkg::CFG_INDEX_W-1:0] cfg_addr;
  logic [tacs_pkg::DATA_W-1:0]      cfg_wdata;

  logic [7:0]   shadow_mem [tacs_pkg::MEM_DEPTH];
  logic [7:0]   shadow_pc;
  logic [7:0]   shadow_a;
  logic [7:0]   shadow_b;
  logic         shadow_halt;
  logic [7:0]   cur_start;
  logic [7:0]   cur_ceiling;
  machine_out_t outcomes [$];
  int           items_sent  = 0;
  int           error_count = 0;
  int           gap_pct     = 0;
  int           stall_pct   = 0;
  bit           hold_req    = 1'b0;

  dir_row_t directed_rows [0:33] = '{
    '{ROW_ITEM, tacs_pkg::KIND_READ,    8'h00, 8'h00,             1'b1, 8'h00, 8'h01},
    '{ROW_ITEM, tacs_pkg::KIND_WRITE,   8'hFF, 8'hFF,             1'b1, 8'h00, 8'h01},
    '{ROW_ITEM, tacs_pkg::KIND_READ,    8'hFF, 8'h00,             1'b1, 8'hFF, 8'h01},
    '{ROW_ITEM, tacs_pkg::KIND_WRITE,   8'h01, tacs_pkg::OP_LDA,  1'b1, 8'h00, 8'h01},
    '{ROW_ITEM, tacs_pkg::KIND_WRITE,   8'h02, 8'hFF,             1'b1, 8'h00, 8'h01},
    '{ROW_ITEM, tacs_pkg::KIND_WRITE,   8'h03, tacs_pkg::OP_LDB,  1'b1, 8'h00, 8'h01},
    '{ROW_ITEM, tacs_pkg::KIND_WRITE,   8'h04, 8'h01,             1'b1, 8'h00, 8'h01},
    '{ROW_ITEM, tacs_pkg::KIND_WRITE,   8'h05, tacs_pkg::OP_ADD,  1'b1, 8'h00, 8'h01},
    '{ROW_ITEM, tacs_pkg::KIND_WRITE,   8'h06, tacs_pkg::OP_BEEP, 1'b1, 8'h00, 8'h01},
    '{ROW_ITEM, tacs_pkg::KIND_WRITE,   8'h07, tacs_pkg::OP_STO,  1'b1, 8'h00, 8'h01},
    '{ROW_ITEM, tacs_pkg::KIND_WRITE,   8'h08, 8'h80,             1'b1, 8'h00, 8'h01},
    '{ROW_ITEM, tacs_pkg::KIND_WRITE,   8'h09, tacs_pkg::OP_PRN,  1'b1, 8'h00, 8'h01},
    '{ROW_ITEM, tacs_pkg::KIND_WRITE,   8'h0A, 8'hFF,             1'b1, 8'h00, 8'h01},
    '{ROW_ITEM, tacs_pkg::KIND_WRITE,   8'h0B, 8'hAA,             1'b1, 8'h00, 8'h01},
    // load, load, wrapping add, beep, store, indirect print, unknown opcode, halt
    '{ROW_ITEM, tacs_pkg::KIND_STEP,    8'h00, 8'h00,             1'b0, 8'h00, 8'h00},
    '{ROW_ITEM, tacs_pkg::KIND_STEP,    8'hFF, 8'hFF,             1'b0, 8'h00, 8'h00},
    '{ROW_ITEM, tacs_pkg::KIND_STEP,    8'h00, 8'h00,             1'b0, 8'h00, 8'h00},
    '{ROW_ITEM, tacs_pkg::KIND_STEP,    8'hFF, 8'hFF,             1'b0, 8'h00, 8'h00},
    '{ROW_ITEM, tacs_pkg::KIND_STEP,    8'h00, 8'h00,             1'b0, 8'h00, 8'h00},
    '{ROW_ITEM, tacs_pkg::KIND_STEP,    8'hFF, 8'hFF,             1'b0, 8'h00, 8'h00},
    '{ROW_ITEM, tacs_pkg::KIND_STEP,    8'h00, 8'h00,             1'b0, 8'h00, 8'h00},
    '{ROW_ITEM, tacs_pkg::KIND_STEP,    8'hFF, 8'hFF,             1'b0, 8'h00, 8'h00},
    // step while halted changes nothing
    '{ROW_ITEM, tacs_pkg::KIND_STEP,    8'h00, 8'h00,             1'b0, 8'h00, 8'h00},
    // open ceiling, run off the top of the counter
    '{ROW_CFG,  tacs_pkg::KIND_WRITE,   8'(tacs_pkg::CFG_CEILING), 8'hFF,
      1'b0, 8'h00, 8'h00},
    '{ROW_CFG,  tacs_pkg::KIND_WRITE,   8'(tacs_pkg::CFG_START),   8'hFD,
      1'b0, 8'h00, 8'h00},
    '{ROW_ITEM, tacs_pkg::KIND_WRITE,   8'hFD, tacs_pkg::OP_LDA,  1'b0, 8'h00, 8'h00},
    '{ROW_ITEM, tacs_pkg::KIND_RESTART, 8'hFF, 8'hFF,             1'b0, 8'h00, 8'h00},
    '{ROW_ITEM, tacs_pkg::KIND_STEP,    8'h00, 8'h00,             1'b0, 8'h00, 8'h00},
    '{ROW_ITEM, tacs_pkg::KIND_STEP,    8'h00, 8'h00,             1'b0, 8'h00, 8'h00},
    // ceiling at the start address: the first fetch passes it and halts
    '{ROW_CFG,  tacs_pkg::KIND_WRITE,   8'(tacs_pkg::CFG_CEILING), 8'h01,
      1'b0, 8'h00, 8'h00},
    '{ROW_CFG,  tacs_pkg::KIND_WRITE,   8'(tacs_pkg::CFG_START),   8'h01,
      1'b0, 8'h00, 8'h00},
    '{ROW_ITEM, tacs_pkg::KIND_RESTART, 8'h00, 8'h00,             1'b0, 8'h00, 8'h00},
    '{ROW_ITEM, tacs_pkg::KIND_STEP,    8'h00, 8'h00,             1'b0, 8'h00, 8'h00},
    '{ROW_ITEM, tacs_pkg::KIND_READ,    8'h00, 8'h00,             1'b0, 8'h00, 8'h00}
  };

  tiny_accumulator_cpu_step_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic machine_out_t step_machine(input logic [1:0] kind,
                                               input logic [7:0] addr,
                                               input logic [7:0] data);
    machine_out_t res;
    logic [7:0]   op;
    res = '0;
    case (kind)
      tacs_pkg::KIND_WRITE: shadow_mem[addr] = data;
      tacs_pkg::KIND_READ: res.read_data = shadow_mem[addr];
      tacs_pkg::KIND_RESTART: begin
        shadow_halt = 1'b0;
        shadow_pc   = cur_start;
      end
      tacs_pkg::KIND_STEP: begin
        if (!shadow_halt) begin
          op = shadow_mem[shadow_pc];
          shadow_pc = shadow_pc + 8'd1;
          shadow_mem[tacs_pkg::OPCODE_SLOT] = op;
          // a fetch past the ceiling halts before the opcode runs
          if (shadow_pc > cur_ceiling) begin
            shadow_halt = 1'b1;
          end else begin
            case (op)
              tacs_pkg::OP_HALT: shadow_halt = 1'b1;
              tacs_pkg::OP_LDA: begin
                shadow_a  = shadow_mem[shadow_pc];
                shadow_pc = shadow_pc + 8'd1;
              end
              tacs_pkg::OP_LDB: begin
                shadow_b  = shadow_mem[shadow_pc];
                shadow_pc = shadow_pc + 8'd1;
              end
              tacs_pkg::OP_ADD: shadow_a = shadow_a + shadow_b;
              tacs_pkg::OP_BEEP: res.beeped = 1'b1;
              tacs_pkg::OP_STO: begin
                shadow_b  = shadow_mem[shadow_pc];
                shadow_pc = shadow_pc + 8'd1;
                shadow_mem[shadow_b] = shadow_a;
              end
              tacs_pkg::OP_PRN: begin
                shadow_b  = shadow_mem[shadow_pc];
                shadow_pc = shadow_pc + 8'd1;
                shadow_a  = shadow_mem[shadow_b];
                res.printed     = 1'b1;
                res.print_value = shadow_a;
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase
    res.halted           = shadow_halt;
    res.program_counter  = shadow_pc;
    res.accumulator      = shadow_a;
    res.operand_register = shadow_b;
    return res;
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) flag_error($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  task automatic send_item(input logic [1:0] kind, input logic [7:0] addr,
                           input logic [7:0] data);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {data, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    outcomes.push_back(step_machine(kind, addr, data));
    items_sent++;
  endtask

  // hold until every expected result is back, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [tacs_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == tacs_pkg::CFG_START) cur_start = value;
    else cur_ceiling = value;
  endtask

  // load a short program at the start address, restart, then step through it with reads and random items mixed in
  task automatic run_program();
    logic [7:0] loc;
    logic [7:0] op;
    logic [7:0] arg;
    int         n_instr;
    int         n_steps;
    loc     = cur_start;
    n_instr = $urandom_range(2, 10);
    repeat (n_instr) begin
      case ($urandom_range(0, 15))
        0, 1:    op = tacs_pkg::OP_LDA;
        2, 3:    op = tacs_pkg::OP_LDB;
        4, 5:    op = tacs_pkg::OP_ADD;
        6:       op = tacs_pkg::OP_BEEP;
        7, 8:    op = tacs_pkg::OP_STO;
        9, 10:   op = tacs_pkg::OP_PRN;
        11:      op = tacs_pkg::OP_HALT;
        default: op = 8'($urandom);
      endcase
      send_item(tacs_pkg::KIND_WRITE, loc, op);
      loc = loc + 8'd1;
      if (op == tacs_pkg::OP_LDA || op == tacs_pkg::OP_LDB ||
          op == tacs_pkg::OP_STO || op == tacs_pkg::OP_PRN) begin
        // point stores and indirect loads back into the program now and then
        if ((op == tacs_pkg::OP_STO || op == tacs_pkg::OP_PRN) && $urandom_range(0, 1) == 0)
          arg = cur_start + 8'($urandom_range(0, 15));
        else
          arg = 8'($urandom);
        send_item(tacs_pkg::KIND_WRITE, loc, arg);
        loc = loc + 8'd1;
      end
    end
    send_item(tacs_pkg::KIND_RESTART, 8'($urandom), 8'($urandom));
    n_steps = n_instr + $urandom_range(0, 4);
    repeat (n_steps) begin
      case ($urandom_range(0, 9))
        0:       send_item(tacs_pkg::KIND_READ, 8'($urandom), 8'($urandom));
        1:       send_item(2'($urandom), 8'($urandom), 8'($urandom));
        default: ;
      endcase
      send_item(tacs_pkg::KIND_STEP, 8'($urandom), 8'($urandom));
    end
  endtask

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    machine_out_t got;
    machine_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[tacs_pkg::OUT_FIELDS_W-1:0];
      if (outcomes.size() == 0) begin
        flag_error("result with no item waiting");
      end else begin
        want = outcomes.pop_front();
        check_field("read_data", got.read_data, want.read_data);
        check_field("printed", 8'(got.printed), 8'(want.printed));
        check_field("print_value", got.print_value, want.print_value);
        check_field("beeped", 8'(got.beeped), 8'(want.beeped));
        check_field("halted", 8'(got.halted), 8'(want.halted));
        check_field("program_counter", got.program_counter, want.program_counter);
        check_field("accumulator", got.accumulator, want.accumulator);
        check_field("operand_register", got.operand_register, want.operand_register);
      end
    end
  end

  initial begin
    logic [7:0]   first_pc;
    logic [7:0]   ceiling_val;
    int           target;
    machine_out_t typed_res;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tuser   = '0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    foreach (shadow_mem[i]) shadow_mem[i] = '0;
    cur_start   = tacs_pkg::START_RESET;
    cur_ceiling = tacs_pkg::CEILING_RESET;
    shadow_pc   = tacs_pkg::START_RESET;
    shadow_a    = '0;
    shadow_b    = '0;
    shadow_halt = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    stall_pct = 15;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].rk == ROW_CFG) begin
        drain();
        write_register(directed_rows[i].addr[tacs_pkg::CFG_INDEX_W-1:0],
                       directed_rows[i].data);
      end else begin
        send_item(directed_rows[i].kind, directed_rows[i].addr, directed_rows[i].data);
        if (directed_rows[i].typed) begin
          typed_res = '0;
          typed_res.read_data       = directed_rows[i].exp_rd;
          typed_res.program_counter = directed_rows[i].exp_pc;
          outcomes[outcomes.size()-1] = typed_res;
        end
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          first_pc    = tacs_pkg::START_RESET;
          ceiling_val = tacs_pkg::CEILING_RESET;
        end
        1: begin first_pc = 8'd0;        ceiling_val = 8'd1;          end
        2: begin first_pc = 8'd253;      ceiling_val = 8'd253;        end
        3: begin first_pc = 8'd0;        ceiling_val = 8'd255;        end
        4: begin first_pc = 8'd240;      ceiling_val = 8'd255;        end
        default: begin
          first_pc = 8'($urandom_range(0, 253));
          if ($urandom_range(0, 3) == 0)
            ceiling_val = 8'($urandom_range(1, 255));
          else if (first_pc > 8'd193)
            ceiling_val = 8'd253;
          else
            ceiling_val = first_pc + 8'($urandom_range(6, 60));
        end
      endcase
      if (p == 2 || p == PHASES - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(3, 25);
        stall_pct = $urandom_range(3, 25);
      end
      drain();
      write_register(tacs_pkg::CFG_START, first_pc);
      write_register(tacs_pkg::CFG_CEILING, ceiling_val);
      // keep offering items while the receiver holds off, so the input backs up
      if (p == 4) begin
        gap_pct  = 0;
        hold_req = 1'b1;
      end
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target - PHASE_ITEMS / 2) run_program();
      if (p == 5) drain();
      while (items_sent < target) run_program();
    end
    drain();

    if (error_count == 0) begin
      $display("tb_tiny_accumulator_cpu_step_core passed");
    end else begin
      $display("tb_tiny_accumulator_cpu_step_core failed");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("tb_tiny_accumulator_cpu_step_core failed");
    $finish;
  end

endmodule

### filelist.f
hdl/tacs_pkg.sv
hdl/tacs_ram.sv
hdl/tacs_ctrl.sv
hdl/tacs_datapath.sv
hdl/tiny_accumulator_cpu_step_core.sv
bench/tb_tiny_accumulator_cpu_step_core.sv
